FILE: design/dcmb_pkg.sv
// dcmb_pkg: shared types, constants and register indexes of the dcm balance controller
// no dependencies
package dcmb_pkg;

  localparam int FracBits = 16;

  typedef enum logic [2:0] {
    REG_PROP_X  = 3'd0,
    REG_PROP_Y  = 3'd1,
    REG_INT_X   = 3'd2,
    REG_INT_Y   = 3'd3,
    REG_ZMP     = 3'd4,
    REG_RETAIN  = 3'd5,
    REG_STIFF   = 3'd6,
    REG_WEIGHT  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] dcm_x;
    logic signed [31:0] dcm_y;
    logic signed [31:0] dcm_target_x;
    logic signed [31:0] dcm_target_y;
    logic signed [31:0] zmp_target_x;
    logic signed [31:0] zmp_target_y;
    logic signed [31:0] zmp_meas_x;
    logic signed [31:0] zmp_meas_y;
    logic signed [31:0] com_x;
    logic signed [31:0] com_y;
    logic signed [31:0] com_z;
    logic               clear_integral;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] zmp_ref_x;
    logic signed [31:0] zmp_ref_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic        [30:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  // saturate a 34 bit signed value to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) begin
      sat34 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat34 = 32'sh8000_0000;
    end else begin
      sat34 = v[31:0];
    end
  endfunction

endpackage

FILE: design/dcmb_if.sv
// dcmb_if: valid/ready channel interfaces for items and configuration writes
// depends on dcmb_pkg
interface dcmb_in_if;
  logic               valid;
  logic               ready;
  dcmb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcmb_out_if;
  logic                valid;
  logic                ready;
  dcmb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcmb_cfg_if;
  logic                valid;
  logic                ready;
  dcmb_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/dcmb_mul.sv
// dcmb_mul: registered fixed point multiply, round to nearest and saturate
// depends on dcmb_pkg
module dcmb_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [31:0] p_o
);
  import dcmb_pkg::*;

  logic signed [65:0] prod;
  logic signed [65:0] shifted;
  logic signed [65:0] hi;
  logic signed [65:0] lo;
  logic signed [31:0] p_d;

  // product plus half lsb, arithmetic shift gives floor
  always_comb begin
    prod    = a_i * b_i + (66'sd1 <<< (FracBits - 1));
    shifted = prod >>> FracBits;
    hi      = 66'sh7FFF_FFFF;
    lo      = -66'sh8000_0000;
    if (shifted > hi) begin
      p_d = 32'sh7FFF_FFFF;
    end else if (shifted < lo) begin
      p_d = 32'sh8000_0000;
    end else begin
      p_d = shifted[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= p_d;
  end
endmodule

FILE: design/dcm_balance_controller.sv
// dcm_balance_controller: top level, sequencer around one shared multiplier
// depends on dcmb_pkg, dcmb_if, dcmb_mul
// For each accepted item a sequencer steps a single registered 33x33 multiplier
// through the sixteen products of the tick in turn, with one accumulator register
// collecting the terms. The next item is taken in the cycle after the result has
// been taken, so no new item is accepted while one is in flight. Configuration
// writes land at once; out of range indexes are ignored.
module dcm_balance_controller (
  input  logic clk_i,
  input  logic rst_ni,
  dcmb_in_if.sink    in_if,
  dcmb_cfg_if.sink   cfg_if,
  dcmb_out_if.source out_if
);
  import dcmb_pkg::*;

  // configuration registers
  logic [30:0] prop_x_q, prop_y_q, int_x_q, int_y_q, zgain_q, stiff_q, weight_q;
  logic [16:0] retain_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_x_q <= 31'(1 << FracBits);
      prop_y_q <= 31'(1 << FracBits);
      int_x_q  <= '0;
      int_y_q  <= '0;
      zgain_q  <= '0;
      retain_q <= 17'(1 << FracBits);
      stiff_q  <= '0;
      weight_q <= '0;
    end else if (cfg_if.valid && cfg_if.data.index[3] == 1'b0) begin
      unique case (reg_idx_e'(cfg_if.data.index[2:0]))
        REG_PROP_X: prop_x_q <= cfg_if.data.data[30:0];
        REG_PROP_Y: prop_y_q <= cfg_if.data.data[30:0];
        REG_INT_X:  int_x_q  <= cfg_if.data.data[30:0];
        REG_INT_Y:  int_y_q  <= cfg_if.data.data[30:0];
        REG_ZMP:    zgain_q  <= cfg_if.data.data[30:0];
        REG_RETAIN: retain_q <= cfg_if.data.data[16:0];
        REG_STIFF:  stiff_q  <= cfg_if.data.data[30:0];
        REG_WEIGHT: weight_q <= cfg_if.data.data[30:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e state_q, state_d;
  logic [5:0] step_q, step_d;
  in_item_t item_q;
  logic signed [31:0] integ_x_q, integ_y_q;
  logic signed [31:0] ex_q, ey_q, dzx_q, dzy_q;
  logic signed [33:0] acc_q;
  logic signed [31:0] rx_q, ry_q, fx_q, fy_q, tx_q, ty_q, tz_q;
  logic signed [31:0] new_ix_q, new_iy_q;

  logic signed [32:0] ma, mb;
  logic signed [31:0] mp;

  dcmb_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(mp));

  function automatic logic signed [32:0] ug(input logic [30:0] g);
    ug = {2'b00, g};
  endfunction
  function automatic logic signed [32:0] sg(input logic signed [31:0] v);
    sg = {v[31], v};
  endfunction
  function automatic logic signed [33:0] sx(input logic signed [31:0] v);
    sx = {{2{v[31]}}, v};
  endfunction

  // operand select: each operand pair is held over its slot, chosen by step_q[5:1]
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_q[5:1])
      5'd0:  begin ma = ug(prop_x_q); mb = sg(ex_q); end
      5'd1:  begin ma = ug(zgain_q); mb = sg(dzx_q); end
      5'd2:  begin ma = ug(prop_y_q); mb = sg(ey_q); end
      5'd3:  begin ma = ug(zgain_q); mb = sg(dzy_q); end
      5'd4:  begin ma = {16'd0, retain_q}; mb = sg(integ_x_q); end
      5'd5:  begin ma = ug(int_x_q); mb = sg(ex_q); end
      5'd6:  begin ma = {16'd0, retain_q}; mb = sg(integ_y_q); end
      5'd7:  begin ma = ug(int_y_q); mb = sg(ey_q); end
      5'd8:  begin ma = ug(stiff_q); mb = sg(sat34(sx(item_q.com_x) - sx(rx_q))); end
      5'd9:  begin ma = ug(stiff_q); mb = sg(sat34(sx(item_q.com_y) - sx(ry_q))); end
      5'd10: begin ma = sg(item_q.com_y); mb = ug(weight_q); end
      5'd11: begin ma = sg(item_q.com_z); mb = sg(fy_q); end
      5'd12: begin ma = sg(item_q.com_z); mb = sg(fx_q); end
      5'd13: begin ma = sg(item_q.com_x); mb = ug(weight_q); end
      5'd14: begin ma = sg(item_q.com_x); mb = sg(fy_q); end
      5'd15: begin ma = sg(item_q.com_y); mb = sg(fx_q); end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: if (in_if.valid) begin
        state_d = ST_RUN;
        step_d  = '0;
      end
      ST_RUN: begin
        step_d = step_q + 6'd1;
        if (step_q == 6'd32) state_d = ST_OUT;
      end
      ST_OUT: if (out_if.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_if.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      integ_x_q <= '0;
      integ_y_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == ST_IDLE && in_if.valid && in_if.data.clear_integral) begin
        integ_x_q <= '0;
        integ_y_q <= '0;
      end else if (state_q == ST_RUN && step_q == 6'd32) begin
        integ_x_q <= new_ix_q;
        integ_y_q <= new_iy_q;
      end
    end
  end

  // datapath, takes each product from the multiplier's output register after its slot
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_if.valid) begin
      item_q <= in_if.data;
      ex_q   <= sat34(sx(in_if.data.dcm_target_x) - sx(in_if.data.dcm_x));
      ey_q   <= sat34(sx(in_if.data.dcm_target_y) - sx(in_if.data.dcm_y));
      dzx_q  <= sat34(sx(in_if.data.zmp_target_x) - sx(in_if.data.zmp_meas_x));
      dzy_q  <= sat34(sx(in_if.data.zmp_target_y) - sx(in_if.data.zmp_meas_y));
    end else if (state_q == ST_RUN) begin
      unique case (step_q)
        6'd2:  acc_q <= sx(item_q.zmp_target_x) - sx(integ_x_q) - sx(mp);
        6'd4:  rx_q  <= sat34(acc_q + sx(mp));
        6'd6:  acc_q <= sx(item_q.zmp_target_y) - sx(integ_y_q) - sx(mp);
        6'd8:  ry_q  <= sat34(acc_q + sx(mp));
        6'd10: acc_q <= sx(mp);
        6'd12: new_ix_q <= sat34(acc_q + sx(mp));
        6'd14: acc_q <= sx(mp);
        6'd16: new_iy_q <= sat34(acc_q + sx(mp));
        6'd18: fx_q <= mp;
        6'd20: fy_q <= mp;
        6'd22: acc_q <= sx(mp);
        6'd24: tx_q <= sat34(acc_q - sx(mp));
        6'd26: acc_q <= sx(mp);
        6'd28: ty_q <= sat34(acc_q - sx(mp));
        6'd30: acc_q <= sx(mp);
        6'd32: tz_q <= sat34(acc_q - sx(mp));
        default: ;
      endcase
    end
  end

  assign out_if.valid          = (state_q == ST_OUT);
  assign out_if.data.zmp_ref_x = rx_q;
  assign out_if.data.zmp_ref_y = ry_q;
  assign out_if.data.force_x   = fx_q;
  assign out_if.data.force_y   = fy_q;
  assign out_if.data.force_z   = weight_q;
  assign out_if.data.torque_x  = tx_q;
  assign out_if.data.torque_y  = ty_q;
  assign out_if.data.torque_z  = tz_q;
endmodule
